@@ rtl/rcce_pkg.sv @@
// ----------------------------------------------------------------------------
// rcce_pkg - shared types and constants of the regex character class engine
// Request and status codes, parser phases, and the byte masks of the
// predefined classes.
// ----------------------------------------------------------------------------
package rcce_pkg;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    ReqBody  = 2'd0,
    ReqQuery = 2'd1,
    ReqLoad  = 2'd2
  } req_e;

  // result status
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StDone  = 2'd1,
    StError = 2'd2
  } status_e;

  // bracket parser phases
  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhBody  = 4'b0010,
    PhEsc   = 4'b0100,
    PhDash  = 4'b1000
  } phase_e;

  // what the last body element was
  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindSingle = 2'd1,
    KindRange  = 2'd2
  } kind_e;

  typedef logic [255:0] byte_map_t;

  localparam logic [7:0] CharCaret  = 8'h5E;
  localparam logic [7:0] CharClose  = 8'h5D;
  localparam logic [7:0] CharDash   = 8'h2D;
  localparam logic [7:0] CharUnder  = 8'h5F;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharVt     = 8'h0B;
  localparam logic [7:0] CharFf     = 8'h0C;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpZ    = 8'h5A;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowZ   = 8'h7A;
  localparam logic [7:0] CharUpD    = 8'h44;
  localparam logic [7:0] CharUpS    = 8'h53;
  localparam logic [7:0] CharUpW    = 8'h57;
  localparam logic [7:0] CharLowD   = 8'h64;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLowR   = 8'h72;
  localparam logic [7:0] CharLowS   = 8'h73;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowV   = 8'h76;
  localparam logic [7:0] CharLowW   = 8'h77;

  // one bit per byte value, set for lo <= value <= hi
  function automatic byte_map_t range_mask(input logic [7:0] lo, input logic [7:0] hi);
    byte_map_t m;
    m = '0;
    for (int i = 0; i < 256; i++) begin
      m[i[7:0]] = (i[7:0] >= lo) && (i[7:0] <= hi);
    end
    return m;
  endfunction

  localparam byte_map_t DigitMask = range_mask(CharZero, CharNine);
  localparam byte_map_t WordMask  = DigitMask
                                  | range_mask(CharLowA, CharLowZ)
                                  | range_mask(CharUpA, CharUpZ)
                                  | range_mask(CharUnder, CharUnder);
  localparam byte_map_t SpaceMask = range_mask(CharSpace, CharSpace)
                                  | range_mask(CharNl, CharNl)
                                  | range_mask(CharCr, CharCr)
                                  | range_mask(CharTab, CharTab);

endpackage

@@ rtl/regex_char_class_engine.sv @@
// ----------------------------------------------------------------------------
// regex_char_class_engine - bracket character class bitmap
// Parses a bracket body one byte per word into a 256-bit membership map,
// loads predefined classes and answers membership queries.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                         | tuser
//  ---------+-----+-------------------------------+--------------
//  s_axis   | in  | [7:0] data_byte               | [1:0] req_type
//  m_axis   | out | [0] member, [2:1] status      | -
//
// One word per cycle sustained while results are taken; each word passes
// through the input register, then the result register.
// The whole map update (range mask, set or clear) is combinational logic
// between those registers.
// Reset clears the map and returns the parser to the start of a class.
// A stalled result holds; one more word is taken into the input register
// meanwhile, then s_axis_tready drops until the result is taken.

module regex_char_class_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] member, [2:1] status, [7:3] zero
);

  // input register
  logic       in_valid_q;
  logic [1:0] in_req_q;
  logic [7:0] in_byte_q;

  // class state
  rcce_pkg::byte_map_t map_q, map_d;
  logic                inv_q, inv_d;
  rcce_pkg::phase_e    phase_q, phase_d;
  rcce_pkg::kind_e     kind_q, kind_d;
  logic [7:0]          prev_q, prev_d;

  // result register
  logic                out_valid_q;
  logic                out_member_q, member_d;
  rcce_pkg::status_e   out_status_q, status_d;

  logic advance;
  logic accept;

  rcce_pkg::byte_map_t map_b;
  logic                inv_b;
  rcce_pkg::phase_e    phase_b;
  rcce_pkg::kind_e     kind_b;
  logic [7:0]          prev_b;
  logic                at_start;
  logic [7:0]          esc_val;
  logic                wr_en;
  logic [7:0]          wr_lo, wr_hi;
  rcce_pkg::byte_map_t wr_mask;

  function automatic logic [7:0] escape_value(input logic [7:0] b);
    logic [7:0] v;
    case (b)
      rcce_pkg::CharLowN: v = rcce_pkg::CharNl;
      rcce_pkg::CharLowT: v = rcce_pkg::CharTab;
      rcce_pkg::CharLowR: v = rcce_pkg::CharCr;
      rcce_pkg::CharLowF: v = rcce_pkg::CharFf;
      rcce_pkg::CharLowV: v = rcce_pkg::CharVt;
      rcce_pkg::CharZero: v = rcce_pkg::CharNul;
      default:            v = b;
    endcase
    return v;
  endfunction

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_req_q  <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // state seen by a body byte: a new class starts from a clean slate
  assign at_start = (phase_q == rcce_pkg::PhStart);
  assign map_b    = at_start ? '0 : map_q;
  assign inv_b    = at_start ? 1'b0 : inv_q;
  assign phase_b  = at_start ? rcce_pkg::PhBody : phase_q;
  assign kind_b   = at_start ? rcce_pkg::KindNone : kind_q;
  assign prev_b   = at_start ? 8'd0 : prev_q;
  assign esc_val  = escape_value(in_byte_q);
  assign wr_mask  = rcce_pkg::range_mask(wr_lo, wr_hi);

  always_comb begin
    map_d    = map_q;
    inv_d    = inv_q;
    phase_d  = phase_q;
    kind_d   = kind_q;
    prev_d   = prev_q;
    member_d = 1'b0;
    status_d = rcce_pkg::StOk;
    wr_en    = 1'b0;
    wr_lo    = in_byte_q;
    wr_hi    = in_byte_q;

    case (in_req_q)
      rcce_pkg::ReqBody: begin
        map_d   = map_b;
        inv_d   = inv_b;
        phase_d = phase_b;
        kind_d  = kind_b;
        prev_d  = prev_b;
        if (at_start && in_byte_q == rcce_pkg::CharCaret) begin
          map_d = '1;
          inv_d = 1'b1;
        end else begin
          unique case (phase_b)
            rcce_pkg::PhEsc: begin
              wr_en   = 1'b1;
              wr_lo   = esc_val;
              wr_hi   = esc_val;
              prev_d  = esc_val;
              kind_d  = rcce_pkg::KindSingle;
              phase_d = rcce_pkg::PhBody;
            end
            rcce_pkg::PhDash: begin
              if (in_byte_q == rcce_pkg::CharDash) begin
                map_d    = '0;
                inv_d    = 1'b0;
                phase_d  = rcce_pkg::PhStart;
                kind_d   = rcce_pkg::KindNone;
                prev_d   = 8'd0;
                status_d = rcce_pkg::StError;
              end else if (in_byte_q == rcce_pkg::CharClose) begin
                // pending dash becomes a literal
                wr_en    = 1'b1;
                wr_lo    = rcce_pkg::CharDash;
                wr_hi    = rcce_pkg::CharDash;
                phase_d  = rcce_pkg::PhStart;
                kind_d   = rcce_pkg::KindNone;
                prev_d   = 8'd0;
                status_d = rcce_pkg::StDone;
              end else begin
                wr_en   = 1'b1;
                wr_lo   = (prev_b > in_byte_q) ? in_byte_q : prev_b;
                wr_hi   = (prev_b > in_byte_q) ? prev_b : in_byte_q;
                kind_d  = rcce_pkg::KindRange;
                phase_d = rcce_pkg::PhBody;
              end
            end
            default: begin
              if (in_byte_q == rcce_pkg::CharClose) begin
                phase_d  = rcce_pkg::PhStart;
                kind_d   = rcce_pkg::KindNone;
                prev_d   = 8'd0;
                status_d = rcce_pkg::StDone;
              end else if (in_byte_q == rcce_pkg::CharBslash) begin
                phase_d = rcce_pkg::PhEsc;
              end else if (in_byte_q == rcce_pkg::CharDash) begin
                if (kind_b == rcce_pkg::KindRange) begin
                  map_d    = '0;
                  inv_d    = 1'b0;
                  phase_d  = rcce_pkg::PhStart;
                  kind_d   = rcce_pkg::KindNone;
                  prev_d   = 8'd0;
                  status_d = rcce_pkg::StError;
                end else if (kind_b == rcce_pkg::KindNone) begin
                  // leading dash is a literal
                  wr_en  = 1'b1;
                  prev_d = rcce_pkg::CharDash;
                  kind_d = rcce_pkg::KindSingle;
                end else begin
                  phase_d = rcce_pkg::PhDash;
                end
              end else begin
                wr_en  = 1'b1;
                prev_d = in_byte_q;
                kind_d = rcce_pkg::KindSingle;
              end
            end
          endcase
        end
      end
      rcce_pkg::ReqQuery: begin
        member_d = map_q[in_byte_q];
      end
      rcce_pkg::ReqLoad: begin
        case (in_byte_q)
          rcce_pkg::CharLowD: map_d = rcce_pkg::DigitMask;
          rcce_pkg::CharUpD:  map_d = ~rcce_pkg::DigitMask;
          rcce_pkg::CharLowW: map_d = rcce_pkg::WordMask;
          rcce_pkg::CharUpW:  map_d = ~rcce_pkg::WordMask;
          rcce_pkg::CharLowS: map_d = rcce_pkg::SpaceMask;
          rcce_pkg::CharUpS:  map_d = ~rcce_pkg::SpaceMask;
          default:            map_d = '0;
        endcase
        inv_d   = 1'b0;
        phase_d = rcce_pkg::PhStart;
        kind_d  = rcce_pkg::KindNone;
        prev_d  = 8'd0;
      end
      default: ;
    endcase

    // inverted classes remove entries instead of adding them
    if (wr_en) begin
      map_d = inv_d ? (map_d & ~wr_mask) : (map_d | wr_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      inv_q   <= 1'b0;
      phase_q <= rcce_pkg::PhStart;
      kind_q  <= rcce_pkg::KindNone;
      prev_q  <= 8'd0;
    end else if (advance) begin
      map_q   <= map_d;
      inv_q   <= inv_d;
      phase_q <= phase_d;
      kind_q  <= kind_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_member_q <= member_d;
      out_status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_status_q, out_member_q};

`ifndef ASSERT_OFF
  // a word waiting behind a stalled result is kept
  a_hold_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=>
      (in_valid_q && $stable(in_req_q) && $stable(in_byte_q)))
    else $error("pending word lost while result stalled");

  // an error aborts the class completely
  a_error_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status_d == rcce_pkg::StError) |=>
      (phase_q == rcce_pkg::PhStart && map_q == '0 && !inv_q))
    else $error("parse error left class state behind");

  // a load returns the parser to the start of a class
  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_req_q == rcce_pkg::ReqLoad) |=>
      (phase_q == rcce_pkg::PhStart && kind_q == rcce_pkg::KindNone && !inv_q))
    else $error("load did not restart parser");

  // membership is only reported with an ok status
  a_member_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_member_q) |-> (out_status_q == rcce_pkg::StOk))
    else $error("member set on a non-query result");
`endif

endmodule

@@ dv/tb_regex_char_class_engine.sv @@
// ----------------------------------------------------------------------------
// tb_regex_char_class_engine - stream-level test of the character class engine
// Drives body, query and load words and predicts every result word with its
// own model of the bracket parser and the 256-entry membership map. Results
// are checked in order against the queue of expected words.
// Directed cases come first, then a receiver hold-off that backs up the
// input, then random class sequences with and without idle cycles.
// ----------------------------------------------------------------------------
module tb_regex_char_class_engine;

  // request code the block ignores
  localparam logic [1:0] ReqSpare = 2'd3;
  localparam int         LimitCycles = 400000;

  typedef struct packed {
    logic              member;
    rcce_pkg::status_e status;
  } class_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] data_byte
  logic [1:0] s_axis_tuser;   // [1:0] req_type
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [0] member, [2:1] status, [7:3] zero

  regex_char_class_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predicted parser state
  logic [255:0]     class_map;
  rcce_pkg::phase_e class_phase;
  logic             class_inverted;
  logic [7:0]       last_byte;
  rcce_pkg::kind_e  last_kind;

  class_result_t pending_results[$];
  int            err_count;
  int            words_sent;
  bit            idle_on;
  int            stall_left;
  int            hold_left;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic void set_span(input logic [7:0] lo, input logic [7:0] hi,
                                   input logic v);
    for (int i = int'(lo); i <= int'(hi); i++) class_map[i[7:0]] = v;
  endfunction

  function automatic void restart_class(input bit wipe);
    if (wipe) begin
      class_map      = '0;
      class_inverted = 1'b0;
    end
    class_phase = rcce_pkg::PhStart;
    last_kind   = rcce_pkg::KindNone;
    last_byte   = '0;
  endfunction

  function automatic rcce_pkg::status_e parse_body_byte(input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] v;
    if (class_phase == rcce_pkg::PhStart) begin
      class_map      = '0;
      class_inverted = 1'b0;
      last_kind      = rcce_pkg::KindNone;
      last_byte      = '0;
      class_phase    = rcce_pkg::PhBody;
      if (b == rcce_pkg::CharCaret) begin
        class_map      = '1;
        class_inverted = 1'b1;
        return rcce_pkg::StOk;
      end
    end
    case (class_phase)
      rcce_pkg::PhEsc: begin
        case (b)
          rcce_pkg::CharLowN: v = rcce_pkg::CharNl;
          rcce_pkg::CharLowT: v = rcce_pkg::CharTab;
          rcce_pkg::CharLowR: v = rcce_pkg::CharCr;
          rcce_pkg::CharLowF: v = rcce_pkg::CharFf;
          rcce_pkg::CharLowV: v = rcce_pkg::CharVt;
          rcce_pkg::CharZero: v = rcce_pkg::CharNul;
          default:            v = b;
        endcase
        class_map[v] = ~class_inverted;
        last_byte    = v;
        last_kind    = rcce_pkg::KindSingle;
        class_phase  = rcce_pkg::PhBody;
        return rcce_pkg::StOk;
      end
      rcce_pkg::PhDash: begin
        if (b == rcce_pkg::CharDash) begin
          restart_class(1'b1);
          return rcce_pkg::StError;
        end
        if (b == rcce_pkg::CharClose) begin
          class_map[rcce_pkg::CharDash] = ~class_inverted;
          restart_class(1'b0);
          return rcce_pkg::StDone;
        end
        // reversed ends are swapped
        lo = (last_byte > b) ? b : last_byte;
        hi = (last_byte > b) ? last_byte : b;
        set_span(lo, hi, ~class_inverted);
        last_kind   = rcce_pkg::KindRange;
        class_phase = rcce_pkg::PhBody;
        return rcce_pkg::StOk;
      end
      default: begin
        if (b == rcce_pkg::CharClose) begin
          restart_class(1'b0);
          return rcce_pkg::StDone;
        end
        if (b == rcce_pkg::CharBslash) begin
          class_phase = rcce_pkg::PhEsc;
          return rcce_pkg::StOk;
        end
        if (b == rcce_pkg::CharDash) begin
          if (last_kind == rcce_pkg::KindRange) begin
            restart_class(1'b1);
            return rcce_pkg::StError;
          end
          if (last_kind == rcce_pkg::KindSingle) begin
            class_phase = rcce_pkg::PhDash;
            return rcce_pkg::StOk;
          end
        end
        class_map[b] = ~class_inverted;
        last_byte    = b;
        last_kind    = rcce_pkg::KindSingle;
        return rcce_pkg::StOk;
      end
    endcase
  endfunction

  function automatic void load_class_map(input logic [7:0] letter);
    class_map = '0;
    if (letter inside {rcce_pkg::CharLowD, rcce_pkg::CharUpD,
                       rcce_pkg::CharLowW, rcce_pkg::CharUpW}) begin
      set_span(rcce_pkg::CharZero, rcce_pkg::CharNine, 1'b1);
    end
    if (letter inside {rcce_pkg::CharLowW, rcce_pkg::CharUpW}) begin
      set_span(rcce_pkg::CharLowA, rcce_pkg::CharLowZ, 1'b1);
      set_span(rcce_pkg::CharUpA, rcce_pkg::CharUpZ, 1'b1);
      class_map[rcce_pkg::CharUnder] = 1'b1;
    end
    if (letter inside {rcce_pkg::CharLowS, rcce_pkg::CharUpS}) begin
      class_map[rcce_pkg::CharSpace] = 1'b1;
      class_map[rcce_pkg::CharNl]    = 1'b1;
      class_map[rcce_pkg::CharCr]    = 1'b1;
      class_map[rcce_pkg::CharTab]   = 1'b1;
    end
    if (letter inside {rcce_pkg::CharUpD, rcce_pkg::CharUpW, rcce_pkg::CharUpS}) begin
      class_map = ~class_map;
    end
    class_inverted = 1'b0;
    restart_class(1'b0);
  endfunction

  function automatic class_result_t predict_class_result(input logic [1:0] req,
                                                         input logic [7:0] b);
    class_result_t r;
    r.member = 1'b0;
    r.status = rcce_pkg::StOk;
    case (req)
      rcce_pkg::ReqBody:  r.status = parse_body_byte(b);
      rcce_pkg::ReqQuery: r.member = class_map[b];
      rcce_pkg::ReqLoad:  load_class_map(b);
      default:  ;
    endcase
    return r;
  endfunction

  // call right after an accepting edge or at the start; valid stays high
  // across back-to-back words
  task automatic push_word(input logic [1:0] req, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_class_result(req, b));
    words_sent++;
  endtask

  // receiver: per-word stall, plus an optional long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    class_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      stall_left = idle_on ? $urandom_range(0, 6) : 0;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.member)
          report_mismatch("member", int'(m_axis_tdata[0]), int'(want.member));
        if (m_axis_tdata[2:1] !== want.status)
          report_mismatch("status", int'(m_axis_tdata[2:1]), int'(want.status));
        if (m_axis_tdata[7:3] !== 5'd0)
          report_mismatch("pad bits", int'(m_axis_tdata[7:3]), 0);
      end
    end
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b inside {rcce_pkg::CharClose, rcce_pkg::CharBslash,
                     rcce_pkg::CharDash, rcce_pkg::CharCaret});
    return b;
  endfunction

  task automatic test_loads();
    push_word(rcce_pkg::ReqLoad, rcce_pkg::CharLowD);
    push_word(rcce_pkg::ReqQuery, rcce_pkg::CharNine);
    push_word(rcce_pkg::ReqLoad, rcce_pkg::CharUpW);
    push_word(rcce_pkg::ReqQuery, 8'd0);
    push_word(rcce_pkg::ReqLoad, rcce_pkg::CharUpS);
    push_word(rcce_pkg::ReqQuery, 8'd255);
    push_word(rcce_pkg::ReqLoad, 8'h71);     // not a class letter
    push_word(rcce_pkg::ReqQuery, rcce_pkg::CharLowA);
  endtask

  task automatic test_bracket_cases();
    // inverted class closed at once
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharCaret);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharClose);
    push_word(rcce_pkg::ReqQuery, 8'd255);
    // leading dash, reversed range, dash after a range
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharLowZ);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharLowA);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    // escape, then dash as range end
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharBslash);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharLowN);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    // close right after a dash
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharLowA);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
    push_word(rcce_pkg::ReqBody, rcce_pkg::CharClose);
    push_word(rcce_pkg::ReqQuery, rcce_pkg::CharDash);
    push_word(ReqSpare, 8'd255);
  endtask

  task automatic test_output_backpressure();
    idle_on   = 1'b0;
    hold_left = 150;
    for (int i = 0; i < 16; i++) push_word(2'($urandom_range(0, 3)), 8'($urandom));
  endtask

  task automatic test_random_classes(input int n, input bit idle);
    int         target;
    int         pick;
    logic [7:0] b;
    logic [7:0] probe;
    idle_on = idle;
    target  = words_sent + n;
    while (words_sent < target) begin
      pick  = $urandom_range(0, 99);
      probe = 8'($urandom);
      if (pick < 65) begin
        if ($urandom_range(0, 2) == 0) push_word(rcce_pkg::ReqBody, rcce_pkg::CharCaret);
        if ($urandom_range(0, 9) == 0) push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              probe = plain_byte();
              push_word(rcce_pkg::ReqBody, probe);
            end
            5, 6: begin
              push_word(rcce_pkg::ReqBody, rcce_pkg::CharBslash);
              case ($urandom_range(0, 9))
                0: b = rcce_pkg::CharLowN;  1: b = rcce_pkg::CharLowT;
                2: b = rcce_pkg::CharLowR;  3: b = rcce_pkg::CharLowF;
                4: b = rcce_pkg::CharLowV;  5: b = rcce_pkg::CharZero;
                6: b = rcce_pkg::CharClose; 7: b = rcce_pkg::CharDash;
                default: b = 8'($urandom);
              endcase
              push_word(rcce_pkg::ReqBody, b);
            end
            default: begin
              probe = plain_byte();
              push_word(rcce_pkg::ReqBody, probe);
              push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
              do b = 8'($urandom);
              while (b inside {rcce_pkg::CharDash, rcce_pkg::CharClose});
              push_word(rcce_pkg::ReqBody, b);
            end
          endcase
        end
        if ($urandom_range(0, 9) == 0) begin
          // broken tail
          push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
          push_word(rcce_pkg::ReqBody, rcce_pkg::CharDash);
        end else begin
          push_word(rcce_pkg::ReqBody, rcce_pkg::CharClose);
        end
      end else if (pick < 85) begin
        case ($urandom_range(0, 7))
          0: b = rcce_pkg::CharLowD; 1: b = rcce_pkg::CharUpD;
          2: b = rcce_pkg::CharLowW; 3: b = rcce_pkg::CharUpW;
          4: b = rcce_pkg::CharLowS; 5: b = rcce_pkg::CharUpS;
          default: b = 8'($urandom);
        endcase
        push_word(rcce_pkg::ReqLoad, b);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          b = ($urandom_range(0, 1) == 0) ? 8'($urandom)
              : (($urandom_range(0, 1) == 0) ? rcce_pkg::CharDash : rcce_pkg::CharClose);
          push_word(2'($urandom_range(0, 3)), b);
        end
      end
      repeat ($urandom_range(1, 5)) begin
        b = ($urandom_range(0, 2) == 0) ? probe : 8'($urandom);
        push_word(rcce_pkg::ReqQuery, b);
      end
    end
  endtask

  initial begin
    #(12 * LimitCycles);
    $display("tb_regex_char_class_engine: FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rcce_pkg::ReqBody;
    err_count     = 0;
    words_sent    = 0;
    idle_on       = 1'b1;
    stall_left    = 0;
    hold_left     = 0;
    class_map     = '0;
    class_inverted = 1'b0;
    restart_class(1'b1);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_loads();
    test_bracket_cases();
    test_output_backpressure();
    test_random_classes(800, 1'b1);
    test_random_classes(400, 1'b0);
    test_random_classes(800, 1'b1);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_regex_char_class_engine: PASS");
    end else begin
      $display("tb_regex_char_class_engine: FAIL");
    end
    $finish;
  end

endmodule
